/* hdl/spmhd_pkg.sv */
// Shared types and constants of the stereo peak meter with hold and decay.
// No dependencies; spmhd_req_if and every module of the block use this package.
package spmhd_pkg;

   // Transaction kinds on the request channel.
   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_RAW    = 2'd1,
      KIND_DAMPED = 2'd2,
      KIND_HOLD   = 2'd3
   } kind_type;

   // Channel (view) codes of a read.
   localparam logic [1:0] VIEW_A    = 2'd0;
   localparam logic [1:0] VIEW_B    = 2'd1;
   localparam logic [1:0] VIEW_BOTH = 2'd2;
   localparam int unsigned VIEW_COUNT = 3;

   // Configuration registers.
   localparam int unsigned FACTOR_BITS = 17;
   localparam int unsigned HOLD_BITS   = 16;
   localparam int unsigned CSR_DATA_BITS  = FACTOR_BITS;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DAMPING = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD    = 1'd1;

   localparam logic [FACTOR_BITS-1:0] FACTOR_ONE    = 17'd65536;
   localparam logic [FACTOR_BITS-1:0] DAMPING_RESET = 17'd6554;
   localparam logic [HOLD_BITS-1:0]   HOLD_RESET    = 16'd10;
   localparam int unsigned FACTOR_FRAC = 16;

   // Control that the top level hands to the peak tracker and view state.
   typedef struct packed {
      logic       sample_en;  // a sample frame updates the running peaks
      logic       take_en;    // a raw or damped read takes and clears a peak
      logic       damped_en;  // the read is a damped read
      logic       view_ok;    // channel code names a real view
      logic [1:0] view;
      kind_type   kind;
   } view_ctl_type;

endpackage

/* hdl/spmhd_req_if.sv */
// Request channel of the peak meter: valid/ready plus sample or read payload.
// Depends on spmhd_pkg for the kind type.
interface spmhd_req_if #(
   parameter int unsigned SAMPLE_BITS = 24
);
   logic                      valid;
   logic                      ready;
   spmhd_pkg::kind_type       kind;
   logic [1:0]                channel;
   logic signed [SAMPLE_BITS-1:0] sample_a;
   logic signed [SAMPLE_BITS-1:0] sample_b;

   modport source (output valid, kind, channel, sample_a, sample_b, input ready);
   modport sink   (input valid, kind, channel, sample_a, sample_b, output ready);
endinterface

/* hdl/spmhd_rsp_if.sv */
// Result channel of the peak meter: valid/ready plus the linear level.
// No dependencies.
interface spmhd_rsp_if #(
   parameter int unsigned SAMPLE_BITS = 24
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-2:0] level;

   modport source (output valid, level, input ready);
   modport sink   (input valid, level, output ready);
endinterface

/* hdl/spmhd_peak_track.sv */
// Per-channel running peak registers: magnitude, saturation, take and clear.
// Depends on spmhd_pkg.
module spmhd_peak_track #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spmhd_pkg::view_ctl_type       ctl,
   input  logic signed [SAMPLE_BITS-1:0] sample_a,
   input  logic signed [SAMPLE_BITS-1:0] sample_b,
   output logic [SAMPLE_BITS-2:0]        peak
);
   import spmhd_pkg::*;

   localparam int unsigned LEVEL_BITS = SAMPLE_BITS - 1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

   logic [LEVEL_BITS-1:0] peak_a_ff, peak_a_in;
   logic [LEVEL_BITS-1:0] peak_b_ff, peak_b_in;
   logic [SAMPLE_BITS-1:0] abs_a, abs_b;
   logic [LEVEL_BITS-1:0] mag_a, mag_b;

   // Only the most negative sample leaves the sign bit set after negation.
   always_comb begin
      abs_a = sample_a[SAMPLE_BITS-1] ? (~sample_a + 1'b1) : sample_a;
      abs_b = sample_b[SAMPLE_BITS-1] ? (~sample_b + 1'b1) : sample_b;
      mag_a = abs_a[SAMPLE_BITS-1] ? LEVEL_MAX : abs_a[LEVEL_BITS-1:0];
      mag_b = abs_b[SAMPLE_BITS-1] ? LEVEL_MAX : abs_b[LEVEL_BITS-1:0];
   end

   always_comb begin
      unique case (ctl.view)
         VIEW_A:    peak = peak_a_ff;
         VIEW_B:    peak = peak_b_ff;
         VIEW_BOTH: peak = (peak_b_ff > peak_a_ff) ? peak_b_ff : peak_a_ff;
         default:   peak = '0;
      endcase
   end

   always_comb begin
      peak_a_in = peak_a_ff;
      peak_b_in = peak_b_ff;
      if (ctl.sample_en) begin
         if (mag_a > peak_a_ff) peak_a_in = mag_a;
         if (mag_b > peak_b_ff) peak_b_in = mag_b;
      end else if (ctl.take_en) begin
         if (ctl.view == VIEW_A || ctl.view == VIEW_BOTH) peak_a_in = '0;
         if (ctl.view == VIEW_B || ctl.view == VIEW_BOTH) peak_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_a_ff <= '0;
         peak_b_ff <= '0;
      end else begin
         peak_a_ff <= peak_a_in;
         peak_b_ff <= peak_b_in;
      end
   end

endmodule

/* hdl/spmhd_view_state.sv */
// Per-view damped level, hold level and hold counter, plus result selection.
// Depends on spmhd_pkg.
module spmhd_view_state #(
   parameter int unsigned LEVEL_BITS = 23
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  spmhd_pkg::view_ctl_type                ctl,
   input  logic [LEVEL_BITS-1:0]                  peak,
   input  logic [spmhd_pkg::FACTOR_BITS-1:0]      damping_factor,
   input  logic [spmhd_pkg::HOLD_BITS-1:0]        hold_limit,
   output logic [LEVEL_BITS-1:0]                  level
);
   import spmhd_pkg::*;

   localparam logic [LEVEL_BITS:0] LEVEL_MAX_W = {1'b0, {LEVEL_BITS{1'b1}}};

   logic [LEVEL_BITS-1:0] damped_ff [VIEW_COUNT];
   logic [LEVEL_BITS-1:0] hold_ff   [VIEW_COUNT];
   logic [HOLD_BITS-1:0]  count_ff  [VIEW_COUNT];

   logic [1:0]                        idx;
   logic [LEVEL_BITS+FACTOR_BITS-1:0] product;
   logic [LEVEL_BITS:0]               decayed;
   logic [LEVEL_BITS:0]               damped_wide;
   logic [LEVEL_BITS-1:0]             damped_in;
   logic [LEVEL_BITS-1:0]             hold_in;
   logic [HOLD_BITS-1:0]              count_in;

   // An unused channel code never reaches the arrays.
   assign idx = ctl.view_ok ? ctl.view : VIEW_A;

   always_comb begin
      product     = damped_ff[idx] * damping_factor;
      decayed     = product[LEVEL_BITS+FACTOR_FRAC:FACTOR_FRAC];
      damped_wide = ({1'b0, peak} < decayed) ? decayed : {1'b0, peak};
      if (damped_wide > LEVEL_MAX_W) damped_wide = LEVEL_MAX_W;
      damped_in   = damped_wide[LEVEL_BITS-1:0];
   end

   // Hold rises at once, then counts down before following the peak again.
   always_comb begin
      hold_in  = hold_ff[idx];
      count_in = count_ff[idx];
      priority if (hold_ff[idx] < peak) begin
         hold_in  = peak;
         count_in = hold_limit;
      end else if (count_ff[idx] != '0) begin
         count_in = count_ff[idx] - 1'b1;
      end else begin
         hold_in = peak;
      end
   end

   always_comb begin
      level = '0;
      if (ctl.view_ok) begin
         unique case (ctl.kind)
            KIND_RAW:    level = peak;
            KIND_DAMPED: level = damped_in;
            KIND_HOLD:   level = hold_ff[idx];
            KIND_SAMPLE: level = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VIEW_COUNT; i++) begin
            damped_ff[i] <= '0;
            hold_ff[i]   <= '0;
            count_ff[i]  <= '0;
         end
      end else if (ctl.take_en) begin
         hold_ff[idx]  <= hold_in;
         count_ff[idx] <= count_in;
         if (ctl.damped_en) damped_ff[idx] <= damped_in;
      end
   end

endmodule

/* hdl/stereo_peak_meter_hold_decay.sv */
// Top level of the stereo peak meter with peak hold and decay.
// Depends on spmhd_pkg, spmhd_req_if, spmhd_rsp_if, spmhd_peak_track, spmhd_view_state.
//
//   Port      Direction  Carries
//   req_chan  in         sample frames and read requests (kind, channel, samples)
//   rsp_chan  out        one level per read request
//   csr_*     in         damping factor and hold limit writes
//
// A transaction passes an input register, then combinational compare, multiply
// and select logic that updates the peak and view state, then the result
// register; one new transaction every cycle while the result channel does not stall.
// Sample frames produce no result and never wait on the result channel.
// Synchronous reset clears peaks, view state and valid flags, and sets CSR defaults.
// A stalled result holds its register; the input register still drains samples.
module stereo_peak_meter_hold_decay #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   spmhd_req_if.sink                               req_chan,
   spmhd_rsp_if.source                             rsp_chan,
   input  logic                                    csr_we,
   input  logic [spmhd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [spmhd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import spmhd_pkg::*;

   localparam int unsigned LEVEL_BITS = SAMPLE_BITS - 1;

   // Configuration registers.
   logic [FACTOR_BITS-1:0] damping_ff, damping_in;
   logic [HOLD_BITS-1:0]   hold_limit_ff, hold_limit_in;

   // Input register stage.
   logic                          in_valid_ff, in_valid_in;
   kind_type                      kind_ff;
   logic [1:0]                    channel_ff;
   logic signed [SAMPLE_BITS-1:0] sample_a_ff, sample_b_ff;

   // Result register stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] level_ff;
   logic [LEVEL_BITS-1:0] level;
   logic [LEVEL_BITS-1:0] peak;

   logic         advance;
   logic         is_sample;
   logic         accept;
   view_ctl_type ctl;

   always_comb begin
      damping_in    = damping_ff;
      hold_limit_in = hold_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DAMPING: damping_in = (csr_wdata > FACTOR_ONE) ? FACTOR_ONE : csr_wdata;
            CSR_HOLD:    hold_limit_in = csr_wdata[HOLD_BITS-1:0];
            default:     ;
         endcase
      end
   end

   assign is_sample = (kind_ff == KIND_SAMPLE);
   assign advance   = in_valid_ff && (is_sample || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept    = req_chan.valid && req_chan.ready;

   always_comb begin
      ctl.kind      = kind_ff;
      ctl.view      = channel_ff;
      ctl.view_ok   = (channel_ff == VIEW_A) || (channel_ff == VIEW_B)
                      || (channel_ff == VIEW_BOTH);
      ctl.sample_en = advance && is_sample;
      ctl.take_en   = advance && ctl.view_ok
                      && (kind_ff == KIND_RAW || kind_ff == KIND_DAMPED);
      ctl.damped_en = kind_ff == KIND_DAMPED;
   end

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && !is_sample) || (rsp_valid_ff && !rsp_chan.ready);

   spmhd_peak_track #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_peak_track (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample_a (sample_a_ff),
      .sample_b (sample_b_ff),
      .peak     (peak)
   );

   spmhd_view_state #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_view_state (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .peak           (peak),
      .damping_factor (damping_ff),
      .hold_limit     (hold_limit_ff),
      .level          (level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff    <= DAMPING_RESET;
         hold_limit_ff <= HOLD_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         damping_ff    <= damping_in;
         hold_limit_ff <= hold_limit_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_chan.kind;
         channel_ff  <= req_chan.channel;
         sample_a_ff <= req_chan.sample_a;
         sample_b_ff <= req_chan.sample_b;
      end
      if (advance && !is_sample) begin
         level_ff <= level;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.level = level_ff;

   // A sample frame never creates a result on an empty result register.
   a_sample_no_result: assert property (@(posedge clock) disable iff (reset)
      advance && is_sample && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("sample frame produced a result");

   // Every read that leaves the input register shows up as a result.
   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && !is_sample |=> rsp_valid_ff)
      else $error("read transaction lost its result");

   // A stalled input register keeps its transaction.
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(kind_ff) && $stable(channel_ff))
      else $error("stalled request overwritten");

   // The damping factor never exceeds one.
   a_factor_clamped: assert property (@(posedge clock) disable iff (reset)
      damping_ff <= FACTOR_ONE)
      else $error("damping factor above one");

endmodule

/* test/spmhd_level_checker.sv */
// Scoreboard for the stereo peak meter: predicts the level of every read and checks results.
// Depends on spmhd_pkg and the spmhd_req_if / spmhd_rsp_if interfaces.
module spmhd_level_checker #(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   spmhd_req_if                                 req_mon,
   spmhd_rsp_if                                 rsp_mon,
   input  logic                                 csr_we,
   input  logic [spmhd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spmhd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned                          pending,
   output int unsigned                          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spmhd_pkg::*;

   localparam int unsigned LEVEL_BITS = SAMPLE_BITS - 1;
   typedef logic [LEVEL_BITS-1:0] level_type;
   localparam level_type LEVEL_TOP = '1;

   logic [FACTOR_BITS-1:0] damping;
   logic [HOLD_BITS-1:0]   hold_limit;
   level_type              peak_now [2];
   level_type              damped [VIEW_COUNT];
   level_type              held [VIEW_COUNT];
   logic [HOLD_BITS-1:0]   hold_left [VIEW_COUNT];
   level_type              expected_levels [$];
   int unsigned            misses;

   // The most negative sample has no positive twin and saturates to the top level.
   function automatic level_type sample_mag(logic [SAMPLE_BITS-1:0] s);
      logic [SAMPLE_BITS-1:0] m;
      m = s[SAMPLE_BITS-1] ? ~s + 1'b1 : s;
      if (m > LEVEL_TOP) begin
         return LEVEL_TOP;
      end
      return m[LEVEL_BITS-1:0];
   endfunction

   // Takes and clears the running peak of a view, then moves its hold value.
   function automatic level_type claim_peak(logic [1:0] v);
      level_type p;
      if (v == VIEW_BOTH) begin
         p = (peak_now[1] > peak_now[0]) ? peak_now[1] : peak_now[0];
         peak_now[0] = '0;
         peak_now[1] = '0;
      end else begin
         p = peak_now[v];
         peak_now[v] = '0;
      end
      if (held[v] < p) begin
         held[v] = p;
         hold_left[v] = hold_limit;
      end else if (hold_left[v] != 0) begin
         hold_left[v] = hold_left[v] - 1'b1;
      end else begin
         held[v] = p;
      end
      return p;
   endfunction

   function automatic level_type predict_read_level(kind_type kind, logic [1:0] view);
      logic [FACTOR_BITS+LEVEL_BITS-1:0] decayed;
      level_type lvl;
      lvl = '0;
      // A read of the unused channel code returns zero and leaves all state alone.
      if (view <= VIEW_BOTH) begin
         case (kind)
            KIND_RAW: lvl = claim_peak(view);
            KIND_DAMPED: begin
               // The factor is at most 1.0, so the decayed value stays within range.
               decayed = (damped[view] * damping) >> FACTOR_FRAC;
               lvl = claim_peak(view);
               if (lvl < decayed) begin
                  lvl = decayed[LEVEL_BITS-1:0];
               end
               damped[view] = lvl;
            end
            KIND_HOLD: lvl = held[view];
            default: ;
         endcase
      end
      return lvl;
   endfunction

   always @(posedge clock) begin : watch
      level_type want;
      level_type mag;
      if (reset) begin
         damping = DAMPING_RESET;
         hold_limit = HOLD_RESET;
         peak_now[0] = '0;
         peak_now[1] = '0;
         for (int i = 0; i < VIEW_COUNT; i++) begin
            damped[i] = '0;
            held[i] = '0;
            hold_left[i] = '0;
         end
         expected_levels.delete();
         misses = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected result transaction, level %0d",
                        $time, rsp_mon.level);
               misses++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_mon.level !== want) begin
                  $display("%0t: level mismatch, expected %0d, actual %0d",
                           $time, want, rsp_mon.level);
                  misses++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_SAMPLE) begin
               mag = sample_mag(req_mon.sample_a);
               if (mag > peak_now[0]) begin
                  peak_now[0] = mag;
               end
               mag = sample_mag(req_mon.sample_b);
               if (mag > peak_now[1]) begin
                  peak_now[1] = mag;
               end
            end else begin
               expected_levels.push_back(predict_read_level(req_mon.kind, req_mon.channel));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DAMPING: damping = (csr_wdata > FACTOR_ONE) ? FACTOR_ONE : csr_wdata;
               CSR_HOLD:    hold_limit = csr_wdata[HOLD_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_levels.size();
      fail_count <= misses;
   end

endmodule

/* test/stereo_peak_meter_hold_decay_tb.sv */
// Top of the peak meter testbench: clock, reset, stimulus, register writes and verdict.
// Depends on spmhd_pkg, both channel interfaces, the block and spmhd_level_checker.
module stereo_peak_meter_hold_decay_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spmhd_pkg::*;

   localparam int unsigned SB           = 24;
   localparam int unsigned TAIL_CYCLES  = 6;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned PHASE_ITEMS  = 175;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int unsigned               pending;
   int unsigned               fail_count;
   int unsigned               cycle_count = 0;
   int unsigned               items_sent = 0;
   int unsigned               stall_left = 0;
   bit                        pace_on;

   spmhd_req_if #(.SAMPLE_BITS(SB)) req_chan ();
   spmhd_rsp_if #(.SAMPLE_BITS(SB)) rsp_chan ();

   stereo_peak_meter_hold_decay #(.SAMPLE_BITS(SB)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   spmhd_level_checker #(.SAMPLE_BITS(SB)) level_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned pause_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // Full-scale extremes, zero and minus one, otherwise random values of random magnitude.
   function automatic logic [SB-1:0] rand_sample();
      logic signed [SB-1:0] v;
      case ($urandom_range(0, 9))
         0: v = {1'b1, {(SB-1){1'b0}}};
         1: v = {1'b0, {(SB-1){1'b1}}};
         2: v = '0;
         3: v = '1;
         default: begin
            v = SB'($urandom);
            v = v >>> $urandom_range(0, SB - 1);
         end
      endcase
      return v;
   endfunction

   function automatic logic [1:0] rand_view();
      return ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
   endfunction

   always @(posedge clock) begin
      if (reset || !pace_on) begin
         rsp_chan.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = pause_len() - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Valid stays high after acceptance so that back-to-back transactions need no toggle.
   task automatic send_item(kind_type kind, logic [1:0] ch, logic [SB-1:0] a, logic [SB-1:0] b);
      int unsigned gap;
      gap = (pace_on && $urandom_range(0, 2) == 0) ? pause_len() : 0;
      if (gap != 0) begin
         req_chan.valid    <= 1'b0;
         req_chan.kind     <= kind_type'($urandom_range(0, 3));
         req_chan.channel  <= 2'($urandom_range(0, 3));
         req_chan.sample_a <= rand_sample();
         req_chan.sample_b <= rand_sample();
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.kind     <= kind;
      req_chan.channel  <= ch;
      req_chan.sample_a <= a;
      req_chan.sample_b <= b;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic send_read(kind_type kind, logic [1:0] ch);
      send_item(kind, ch, rand_sample(), rand_sample());
   endtask

   // The checker count is read at the falling edge, clear of the rising-edge updates.
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly bursts of frames followed by a read or two, with loose transactions mixed in.
   task automatic run_phase(int unsigned count);
      int unsigned target;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 4) != 0) begin
            repeat ($urandom_range(0, 6)) begin
               send_item(KIND_SAMPLE, 2'($urandom_range(0, 3)), rand_sample(), rand_sample());
            end
            repeat ($urandom_range(1, 2)) begin
               send_read(kind_type'($urandom_range(1, 3)), rand_view());
            end
         end else begin
            send_item(kind_type'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      rand_sample(), rand_sample());
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      pace_on           = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_DAMPING;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.kind     = KIND_SAMPLE;
      req_chan.channel  = VIEW_A;
      req_chan.sample_a = '0;
      req_chan.sample_b = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-scale and most negative samples, every read kind on every view,
      // the unused channel code, and a frame whose channel field is ignored.
      send_item(KIND_SAMPLE, VIEW_A, 24'h7FFFFF, 24'h800000);
      send_read(KIND_RAW, VIEW_A);
      send_read(KIND_RAW, VIEW_B);
      send_read(KIND_HOLD, VIEW_A);
      send_read(KIND_HOLD, VIEW_B);
      send_item(KIND_SAMPLE, 2'd3, 24'h000000, 24'hFFFFFF);
      send_read(KIND_RAW, VIEW_BOTH);
      send_read(KIND_HOLD, VIEW_BOTH);
      send_item(KIND_SAMPLE, VIEW_B, 24'h7FFFFF, 24'h000064);
      send_read(KIND_DAMPED, VIEW_A);
      send_read(KIND_DAMPED, VIEW_A);
      send_read(KIND_DAMPED, VIEW_B);
      send_read(KIND_DAMPED, VIEW_BOTH);
      send_item(KIND_SAMPLE, VIEW_BOTH, 24'h800000, 24'h800000);
      send_read(KIND_RAW, 2'd3);
      send_read(KIND_DAMPED, 2'd3);
      send_read(KIND_HOLD, 2'd3);
      send_read(KIND_DAMPED, VIEW_BOTH);
      send_read(KIND_RAW, VIEW_A);
      send_read(KIND_HOLD, VIEW_A);

      run_phase(PHASE_ITEMS);
      write_reg(CSR_DAMPING, '0);
      write_reg(CSR_HOLD, '0);
      run_phase(PHASE_ITEMS);
      write_reg(CSR_DAMPING, FACTOR_ONE);
      write_reg(CSR_HOLD, 17'h0FFFF);
      run_phase(PHASE_ITEMS);
      // Above 1.0 the factor clamps.
      write_reg(CSR_DAMPING, 17'h1FFFF);
      write_reg(CSR_HOLD, 17'd1);
      run_phase(PHASE_ITEMS);
      // The top data bit does not belong to the hold limit.
      write_reg(CSR_DAMPING, 17'($urandom_range(0, 65535)));
      write_reg(CSR_HOLD, 17'h10000 | 17'($urandom_range(0, 5)));
      run_phase(PHASE_ITEMS);
      write_reg(CSR_DAMPING, 17'd65535);
      write_reg(CSR_HOLD, 17'($urandom_range(0, 20)));
      run_phase(PHASE_ITEMS);
      write_reg(CSR_DAMPING, 17'($urandom_range(0, 131071)));
      write_reg(CSR_HOLD, 17'd2);
      pace_on = 1'b0;
      run_phase(PHASE_ITEMS);
      settle();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
